>>> design/u8dec_pkg.sv
package u8dec_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [7:0] LeadBase = 8'hC0;
  localparam logic [7:0] LeadSpan = 8'h35;
  localparam logic [7:0] Lead3Min = 8'hE0;
  localparam logic [7:0] Lead4Min = 8'hF0;
  localparam logic [5:0] ContMask = 6'h3F;

  // continuation bytes still expected
  typedef enum logic [1:0] {
    REM_IDLE  = 2'd0,
    REM_ONE   = 2'd1,
    REM_TWO   = 2'd2,
    REM_THREE = 2'd3
  } rem_t;

  typedef struct packed {
    logic                     emit;
    logic [CpWidth-1:0]       code_point;
    logic                     truncated;
  } step_res_t;

endpackage

>>> design/utf8_stream_decoder.sv
// UTF-8 byte stream to code point decoder.
// Input channel: byte_valid/byte_ready with in_byte and end_of_string; one
//   request per byte, end_of_string marks the last byte of a string.
// Output channel: char_valid/char_ready with code_point and truncated; zero
//   or one request per byte. Lead and non-final continuation bytes give none
//   unless they end a string: a cut sequence gives code_point 0, truncated 1.
// Path: an accepted byte is captured in the input register, then decoded and
//   loaded into the output register, where char_valid rises.
// Throughput: one byte per cycle unless char_ready holds a result; decode is
//   a single shift-or step between the input register and the output register.
// Stall: when char_ready is low with a result held, the output register and
//   then the input register fill and byte_ready drops; bytes that produce no
//   result still drain from the input register while the output holds.
// Reset (rst, synchronous): both registers empty, decoder idle with no
//   partial sequence.
module utf8_stream_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  input  logic [7:0]                      in_byte,
  input  logic                            end_of_string,
  output logic                            char_valid,
  input  logic                            char_ready,
  output logic [u8dec_pkg::CpWidth-1:0]   code_point,
  output logic                            truncated
);

  logic                            stage_valid;
  logic [7:0]                      stage_byte;
  logic                            stage_eos;
  logic                            stage_take;
  logic                            load_ready;
  u8dec_pkg::step_res_t            res;
  u8dec_pkg::rem_t                 remaining;

  assign stage_take = stage_valid && (!res.emit || load_ready);
  assign byte_ready = !stage_valid || stage_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_ready) begin
      stage_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready && byte_valid) begin
      stage_byte <= in_byte;
      stage_eos  <= end_of_string;
    end
  end

  u8dec_step u_step (
    .clk           (clk),
    .rst           (rst),
    .take          (stage_take),
    .in_byte       (stage_byte),
    .end_of_string (stage_eos),
    .res           (res),
    .remaining     (remaining)
  );

  u8dec_out_reg u_out (
    .clk             (clk),
    .rst             (rst),
    .load_valid      (stage_valid && res.emit),
    .load_ready      (load_ready),
    .load_code_point (res.code_point),
    .load_truncated  (res.truncated),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .code_point      (code_point),
    .truncated       (truncated)
  );

  assert property (@(posedge clk) disable iff (rst)
    char_valid && truncated |-> code_point == '0)
    else $error("truncated result carries a nonzero code point");
  assert property (@(posedge clk) disable iff (rst)
    char_valid |-> code_point <= 21'h13FFFF)
    else $error("code point out of range");
  assert property (@(posedge clk)
    rst |=> remaining == u8dec_pkg::REM_IDLE && !stage_valid && !char_valid)
    else $error("reset did not clear the decoder");
  assert property (@(posedge clk) disable iff (rst)
    byte_valid && byte_ready |=> stage_valid)
    else $error("accepted byte lost before decode");

endmodule

>>> design/u8dec_step.sv
module u8dec_step (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             take,
  input  logic [7:0]                       in_byte,
  input  logic                             end_of_string,
  output u8dec_pkg::step_res_t             res,
  output u8dec_pkg::rem_t                  remaining
);

  u8dec_pkg::rem_t                 remaining_next;
  logic [u8dec_pkg::CpWidth-1:0]   partial_value;
  logic [u8dec_pkg::CpWidth-1:0]   partial_value_next;
  logic [7:0]                      lead_off;
  logic                            is_lead;
  logic [u8dec_pkg::CpWidth-1:0]   shifted;

  assign lead_off = in_byte - u8dec_pkg::LeadBase;
  assign is_lead  = (in_byte >= u8dec_pkg::LeadBase) && (lead_off < u8dec_pkg::LeadSpan);
  assign shifted  = {partial_value[u8dec_pkg::CpWidth-7:0], in_byte[5:0] & u8dec_pkg::ContMask};

  always_comb begin
    remaining_next     = remaining;
    partial_value_next = partial_value;
    res                = '0;
    if (remaining == u8dec_pkg::REM_IDLE) begin
      if (is_lead) begin
        if (end_of_string) begin
          partial_value_next = '0;
          res.emit           = 1'b1;
          res.truncated      = 1'b1;
        end else if (in_byte >= u8dec_pkg::Lead4Min) begin
          partial_value_next = {18'd0, in_byte[2:0]};
          remaining_next     = u8dec_pkg::REM_THREE;
        end else if (in_byte >= u8dec_pkg::Lead3Min) begin
          partial_value_next = {17'd0, in_byte[3:0]};
          remaining_next     = u8dec_pkg::REM_TWO;
        end else begin
          partial_value_next = {16'd0, in_byte[4:0]};
          remaining_next     = u8dec_pkg::REM_ONE;
        end
      end else begin
        res.emit       = 1'b1;
        res.code_point = {13'd0, in_byte};
      end
    end else begin
      partial_value_next = shifted;
      remaining_next     = u8dec_pkg::rem_t'(remaining - 2'd1);
      if (remaining == u8dec_pkg::REM_ONE) begin
        res.emit       = 1'b1;
        res.code_point = shifted;
      end else if (end_of_string) begin
        remaining_next     = u8dec_pkg::REM_IDLE;
        partial_value_next = '0;
        res.emit           = 1'b1;
        res.truncated      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      remaining     <= u8dec_pkg::REM_IDLE;
      partial_value <= '0;
    end else if (take) begin
      remaining     <= remaining_next;
      partial_value <= partial_value_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    remaining == u8dec_pkg::REM_THREE |-> partial_value[u8dec_pkg::CpWidth-1:3] == '0)
    else $error("partial value too wide with three bytes left");
  assert property (@(posedge clk) disable iff (rst)
    remaining == u8dec_pkg::REM_TWO |-> partial_value[u8dec_pkg::CpWidth-1:9] == '0)
    else $error("partial value too wide with two bytes left");
  assert property (@(posedge clk) disable iff (rst)
    remaining == u8dec_pkg::REM_ONE |-> partial_value[u8dec_pkg::CpWidth-1:15] == '0)
    else $error("partial value too wide with one byte left");

endmodule

>>> design/u8dec_out_reg.sv
module u8dec_out_reg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load_valid,
  output logic                            load_ready,
  input  logic [u8dec_pkg::CpWidth-1:0]   load_code_point,
  input  logic                            load_truncated,
  output logic                            char_valid,
  input  logic                            char_ready,
  output logic [u8dec_pkg::CpWidth-1:0]   code_point,
  output logic                            truncated
);

  assign load_ready = !char_valid || char_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (load_ready) begin
      char_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      code_point <= load_code_point;
      truncated  <= load_truncated;
    end
  end

endmodule
